FILE: rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
		else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
		else $error("assertion failed");
`endif

FILE: rtl/mrpt_pkg.sv
// Package for the Miller-Rabin block: widths, commands and status.
`default_nettype none
package mrpt_pkg;
	localparam int Width = 32;
	localparam int ExpBits = $clog2(Width + 1);
	localparam int BitBits = $clog2(Width);

	typedef logic [Width-1:0] word_t;

	typedef enum logic [2:0] {
		CMD_NONE,
		CMD_LOAD,
		CMD_STRIP,
		CMD_MUL,
		CMD_SQR
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t      op;
		logic         sel_base;
	} cmd_t;

	typedef struct packed {
		logic busy;
		logic d_odd;
		logic a_zero;
		logic x_one;
		logic x_nm1;
		logic e_zero;
		logic e_lsb;
		logic [ExpBits-1:0] s;
	} status_t;
endpackage
`default_nettype wire

FILE: rtl/mrpt_datapath.sv
// Datapath: operand registers and a bit-serial modular multiplier.
`default_nettype none
module mrpt_datapath (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire mrpt_pkg::cmd_t cmd,
	input  wire mrpt_pkg::word_t cand,
	input  wire mrpt_pkg::word_t wit,
	output mrpt_pkg::status_t   status
);
	import mrpt_pkg::*;

	word_t n_q, e_q, b_q, x_q, acc_q, mx_q, my_q;
	logic [ExpBits-1:0] s_q;
	logic [BitBits-1:0] bit_q;
	logic busy_q, dst_b_q, red_q;
	logic [Width:0] dbl, sum;
	word_t dbl_r, add_r, nm1;

	assign nm1 = n_q - word_t'(1);
	// double then conditionally add, each reduced by one compare and subtract
	assign dbl = {acc_q, 1'b0};
	assign dbl_r = (dbl >= {1'b0, n_q}) ? word_t'(dbl - {1'b0, n_q}) : acc_q << 1;
	assign sum = {1'b0, dbl_r} + {1'b0, mx_q};
	assign add_r = (sum >= {1'b0, n_q}) ? word_t'(sum - {1'b0, n_q}) : sum[Width-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= '0;
			e_q <= '0;
			b_q <= '0;
			x_q <= '0;
			acc_q <= '0;
			mx_q <= '0;
			my_q <= '0;
			s_q <= '0;
			bit_q <= '0;
			dst_b_q <= 1'b0;
			busy_q <= 1'b0;
			red_q <= 1'b0;
		end else begin
			case (cmd.op)
				CMD_LOAD: begin
					n_q <= cand;
					e_q <= cand - word_t'(1);
					s_q <= '0;
					x_q <= word_t'(1);
					// reduce witness mod n serially: acc = wit * 1 mod n
					acc_q <= '0;
					mx_q <= word_t'(1);
					my_q <= wit;
					bit_q <= BitBits'(Width - 1);
					busy_q <= 1'b1;
					red_q <= 1'b1;
				end
				CMD_STRIP: begin
					e_q <= e_q >> 1;
					s_q <= s_q + ExpBits'(1);
				end
				CMD_MUL, CMD_SQR: begin
					acc_q <= '0;
					mx_q <= (cmd.op == CMD_MUL || cmd.sel_base) ? b_q : x_q;
					my_q <= cmd.sel_base ? b_q : x_q;
					dst_b_q <= (cmd.op == CMD_SQR) && cmd.sel_base;
					if (cmd.op == CMD_SQR && cmd.sel_base) e_q <= e_q >> 1;
					bit_q <= BitBits'(Width - 1);
					busy_q <= 1'b1;
				end
				default: begin
					if (busy_q) begin
						acc_q <= my_q[bit_q] ? add_r : dbl_r;
						if (bit_q == '0) begin
							busy_q <= 1'b0;
							if (red_q) begin
								b_q <= my_q[bit_q] ? add_r : dbl_r;
								red_q <= 1'b0;
							end else if (dst_b_q) begin
								b_q <= my_q[bit_q] ? add_r : dbl_r;
							end else begin
								x_q <= my_q[bit_q] ? add_r : dbl_r;
							end
						end else begin
							bit_q <= bit_q - BitBits'(1);
						end
					end
				end
			endcase
		end
	end

	assign status.busy = busy_q;
	assign status.d_odd = e_q[0];
	assign status.a_zero = (b_q == '0);
	assign status.x_one = (x_q == word_t'(1));
	assign status.x_nm1 = (x_q == nm1);
	assign status.e_zero = (e_q == '0);
	assign status.e_lsb = e_q[0];
	assign status.s = s_q;
endmodule
`default_nettype wire

FILE: rtl/mrpt_ctrl.sv
// Controller: sequences one Miller round and keeps the running verdict.
`default_nettype none
module mrpt_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_fire,
	input  wire mrpt_pkg::word_t   cand,
	input  wire logic              last,
	input  wire logic              out_taken,
	input  wire mrpt_pkg::status_t status,
	output mrpt_pkg::cmd_t         cmd,
	output logic                   in_rdy,
	output logic                   out_vld,
	output logic                   out_prime,
	output logic                   out_triv
);
	import mrpt_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE, ST_RED, ST_STRIP, ST_POW, ST_MULW, ST_SQRW, ST_CHK,
		ST_SQ, ST_SQW, ST_DONE
	} state_t;

	state_t state_q;
	logic passed_q, last_q, triv_q;
	logic [ExpBits-1:0] k_q;
	logic small_cand, small_pass;

	assign small_cand = (cand <= word_t'(4));
	assign small_pass = (cand == word_t'(2)) || (cand == word_t'(3));
	assign in_rdy = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		cmd_t cmd_d;
		if (!arst_n) begin
			state_q <= ST_IDLE;
			passed_q <= 1'b1;
			last_q <= 1'b0;
			triv_q <= 1'b0;
			k_q <= '0;
			out_vld <= 1'b0;
			out_prime <= 1'b0;
			out_triv <= 1'b0;
			cmd <= '{op: CMD_NONE, sel_base: 1'b0};
		end else begin
			cmd_d = '{op: CMD_NONE, sel_base: 1'b0};
			if (out_vld && out_taken) out_vld <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						last_q <= last;
						triv_q <= small_cand;
						if (small_cand) begin
							passed_q <= passed_q & small_pass;
							state_q <= ST_DONE;
						end else begin
							cmd_d = '{op: CMD_LOAD, sel_base: 1'b0};
							state_q <= ST_RED;
						end
					end
				end
				ST_RED: if (!status.busy && cmd.op == CMD_NONE) begin
					if (status.a_zero) state_q <= ST_DONE;
					else state_q <= ST_STRIP;
				end
				ST_STRIP: if (cmd.op == CMD_NONE) begin
					if (status.d_odd) state_q <= ST_POW;
					else cmd_d = '{op: CMD_STRIP, sel_base: 1'b0};
				end
				ST_POW: begin
					if (status.e_zero) state_q <= ST_CHK;
					else if (status.e_lsb) begin
						cmd_d = '{op: CMD_MUL, sel_base: 1'b0};
						state_q <= ST_MULW;
					end else begin
						cmd_d = '{op: CMD_SQR, sel_base: 1'b1};
						state_q <= ST_SQRW;
					end
				end
				ST_MULW: if (!status.busy && cmd.op == CMD_NONE) begin
					cmd_d = '{op: CMD_SQR, sel_base: 1'b1};
					state_q <= ST_SQRW;
				end
				ST_SQRW: if (!status.busy && cmd.op == CMD_NONE) state_q <= ST_POW;
				ST_CHK: begin
					k_q <= ExpBits'(1);
					if (status.x_one || status.x_nm1) state_q <= ST_DONE;
					else state_q <= ST_SQ;
				end
				ST_SQ: begin
					if (k_q >= status.s) begin
						passed_q <= 1'b0;
						state_q <= ST_DONE;
					end else begin
						cmd_d = '{op: CMD_SQR, sel_base: 1'b0};
						state_q <= ST_SQW;
					end
				end
				ST_SQW: if (!status.busy && cmd.op == CMD_NONE) begin
					k_q <= k_q + ExpBits'(1);
					if (status.x_nm1) state_q <= ST_DONE;
					else if (status.x_one) begin
						passed_q <= 1'b0;
						state_q <= ST_DONE;
					end else state_q <= ST_SQ;
				end
				ST_DONE: begin
					if (!out_vld) begin
						if (last_q) begin
							out_vld <= 1'b1;
							out_prime <= passed_q;
							out_triv <= triv_q;
							passed_q <= 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			cmd <= cmd_d;
		end
	end
endmodule
`default_nettype wire

FILE: rtl/miller_rabin_primality_test.sv
// Top level of the Miller-Rabin primality test block.
`default_nettype none
`include "assert_macros.svh"
// One Miller round per input transfer, with a single bit-serial modular multiplier.
// A round needs at most about 2*Width modular products.
// A verdict transfer follows each item marked last_round, with the output held
// in a register so the next item may enter while it waits.
module miller_rabin_primality_test (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [63:0] s_tdata, // candidate[31:0], witness[63:32]
	input  wire logic        s_tlast, // last_round
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata, // probable_prime[0], trivial_case[1], zero fill
	output logic             m_tlast
);
	import mrpt_pkg::*;

	cmd_t cmd;
	status_t status;
	logic prime, triv, in_fire;
	word_t cand_q, wit_q;

	assign in_fire = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_q <= '0;
			wit_q <= '0;
		end else if (in_fire) begin
			cand_q <= s_tdata[Width-1:0];
			wit_q <= s_tdata[32+Width-1:32];
		end
	end

	mrpt_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd),
		.cand(cand_q), .wit(wit_q), .status(status)
	);

	mrpt_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .cand(s_tdata[Width-1:0]),
		.last(s_tlast), .out_taken(m_tready), .status(status), .cmd(cmd),
		.in_rdy(s_tready), .out_vld(m_tvalid), .out_prime(prime), .out_triv(triv)
	);

	assign m_tdata = {6'b0, triv, prime};
	assign m_tlast = 1'b1;

	`ASSERT_NEXT(a_out_held, clk, arst_n, m_tvalid && !m_tready,
		m_tvalid && $stable(m_tdata))
	`ASSERT_NEXT(a_no_accept_busy, clk, arst_n, in_fire, !s_tready)
	`ASSERT_IMPLIES(a_busy_blocks, clk, arst_n, status.busy, !s_tready)
endmodule
`default_nettype wire

FILE: test/mrpt_checker.sv
// Checker for the Miller-Rabin block: predicts verdicts from accepted rounds and compares them.
`default_nettype none
module mrpt_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [63:0] s_tdata,
	input  wire logic        s_tlast,
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [7:0]  m_tdata,
	output int               failures,
	output int               pending
);
	import mrpt_pkg::*;

	typedef struct packed {
		logic probable_prime;
		logic trivial_case;
	} verdict_t;

	verdict_t verdicts_due[$];
	logic     all_rounds_ok;

	function automatic word_t mod_mul(word_t x, word_t y, word_t n);
		logic [2*Width-1:0] p;
		p = {{Width{1'b0}}, x} * {{Width{1'b0}}, y};
		return word_t'(p % {{Width{1'b0}}, n});
	endfunction

	// Miller round for n >= 5; a residue of zero carries no evidence and passes
	function automatic logic witness_passes(word_t n, word_t a_in);
		word_t a, d, x, e, b;
		int    s;
		a = a_in % n;
		if (a == '0)
			return 1'b1;
		d = n - 1;
		s = 0;
		while (d[0] == 1'b0) begin
			d = d >> 1;
			s++;
		end
		x = 1;
		b = a;
		e = d;
		while (e != '0) begin
			if (e[0])
				x = mod_mul(x, b, n);
			b = mod_mul(b, b, n);
			e = e >> 1;
		end
		if (x == 1 || x == n - 1)
			return 1'b1;
		for (int k = 1; k < s; k++) begin
			x = mod_mul(x, x, n);
			if (x == n - 1)
				return 1'b1;
			if (x == 1)
				return 1'b0;
		end
		return 1'b0;
	endfunction

	assign pending = verdicts_due.size();

	always @(posedge clk or negedge arst_n) begin
		word_t    n, a;
		logic     trivial, pass, acc;
		verdict_t got, want, due;
		if (!arst_n) begin
			all_rounds_ok <= 1'b1;
			failures      <= 0;
			verdicts_due.delete();
		end else begin
			if (s_tvalid && s_tready) begin
				n = s_tdata[Width-1:0];
				a = s_tdata[32 +: Width];
				trivial = (n <= 4);
				pass = trivial ? (n == 2 || n == 3) : witness_passes(n, a);
				acc = all_rounds_ok & pass;
				if (s_tlast) begin
					due = '{acc, trivial};
					verdicts_due = {verdicts_due, due};
					all_rounds_ok <= 1'b1;
				end else begin
					all_rounds_ok <= acc;
				end
			end
			if (m_tvalid && m_tready) begin
				got = '{m_tdata[0], m_tdata[1]};
				if (verdicts_due.size() == 0) begin
					failures <= failures + 1;
					if (failures < 10)
						$display("unexpected verdict transfer: prime=%0b trivial=%0b",
							got.probable_prime, got.trivial_case);
				end else begin
					want = verdicts_due.pop_front();
					if (got != want) begin
						failures <= failures + 1;
						if (failures < 10)
							$display("verdict mismatch: expected prime=%0b trivial=%0b, got prime=%0b trivial=%0b",
								want.probable_prime, want.trivial_case,
								got.probable_prime, got.trivial_case);
					end
				end
			end
		end
	end
endmodule
`default_nettype wire

FILE: test/tb_miller_rabin_primality_test.sv
// Testbench top for the Miller-Rabin block: stimulus, idling and verdict.
`default_nettype none
module tb_miller_rabin_primality_test;
	import mrpt_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic        m_tlast;
	int          failures;
	int          pending;
	int          burst_left = 0;

	miller_rabin_primality_test dut (.*);

	mrpt_checker u_checker (.*);

	always #5 clk = ~clk;

	initial begin
		#30_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	// receiver: ready runs, stall runs, and stretches of random ready
	initial begin
		int mode, len;
		forever begin
			mode = $urandom_range(0, 3);
			len  = $urandom_range(1, 40);
			repeat (len) begin
				@(negedge clk);
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= 1'b0;
					default: m_tready <= ($urandom_range(0, 2) != 0);
				endcase
			end
		end
	end

	// called at a falling edge; returns at the falling edge after the transfer
	task automatic send_round(word_t n, word_t a, logic last);
		if (burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 30)) @(negedge clk);
			burst_left = $urandom_range(1, 8);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {a, n};
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		burst_left--;
		@(negedge clk);
	endtask

	function automatic word_t pick_witness(word_t n);
		if (n > 5 && $urandom_range(0, 9) != 0)
			return word_t'($urandom_range(2, n - 3));
		return $urandom;
	endfunction

	initial begin
		word_t primes[8];
		word_t n;
		int rounds;
		primes = '{5, 7, 65537, 999983, 1000003, 2147483647, 4294967291, 4294967279};
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int k = 0; k <= 4; k++)
			send_round(k, 2, 1'b1);
		send_round(5, 2, 1'b1);
		send_round(561, 2, 1'b1);
		send_round(561, 50, 1'b0);
		send_round(561, 2, 1'b1);
		send_round(4294967291, 2, 1'b0);
		send_round(4294967291, 4294967288, 1'b0);
		send_round(4294967291, 0, 1'b1);
		send_round(4294967291, 4294967291, 1'b1);
		send_round(4294967291, 1, 1'b1);
		send_round(4294967291, 4294967290, 1'b1);
		send_round(4294967295, 32'hFFFF_FFFF, 1'b1);
		send_round(4294967295, 32'hAAAA_5555, 1'b1);
		send_round(2047, 2, 1'b1);
		send_round(3, 0, 1'b0);
		send_round(4, 2, 1'b0);
		send_round(7, 3, 1'b1);
		send_round(25, 7, 1'b1);
		send_round(2147483647, 32'h5555_AAAA, 1'b1);

		s_tvalid <= 1'b0;
		wait (pending == 0);
		@(negedge clk);

		for (int items = 0; items < 120; ) begin
			case ($urandom_range(0, 5))
				0:       n = primes[$urandom_range(0, 7)];
				1:       n = $urandom_range(0, 40);
				2:       n = $urandom | 32'h1;
				default: n = $urandom;
			endcase
			rounds = $urandom_range(1, 4);
			for (int r = 0; r < rounds; r++) begin
				if ($urandom_range(0, 15) == 0)
					n = $urandom;
				send_round(n, pick_witness(n), r == rounds - 1);
				items++;
			end
			if ($urandom_range(0, 9) == 0) begin
				s_tvalid <= 1'b0;
				wait (pending == 0);
				@(negedge clk);
			end
		end

		s_tvalid <= 1'b0;
		wait (pending == 0);
		repeat (3500) @(posedge clk);
		if (failures == 0 && pending == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule
`default_nettype wire
